@@ rtl/iorps_pkg.sv @@
// ----------------------------------------------------------------------------
// iorps_pkg
// Shared widths, limits, state encoding and controller/datapath interface
// types for the request part splitter.
// ----------------------------------------------------------------------------
package iorps_pkg;

   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned SEG_W    = 16;
   localparam int unsigned OFFS_W   = 48;
   localparam int unsigned PLEN_W   = 21;

   localparam logic [PLEN_W-1:0] MAXLEN_LOW   = PLEN_W'(1024);
   localparam logic [PLEN_W-1:0] MAXLEN_HIGH  = PLEN_W'(1048576);
   localparam logic [PLEN_W-1:0] MAXLEN_RESET = PLEN_W'(131072);
   localparam logic [SEG_W-1:0]  SEG_LEN_HIGH = SEG_W'(64512);

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture a new segment
      logic step;     // emit one piece into the output register
      logic cfg_wr;   // write max part length, start a fresh request
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free; // output register empty or being taken this cycle
      logic seg_done; // the piece under way finishes the segment
   } status_type;

endpackage

@@ rtl/io_request_part_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// io_request_part_splitter_unit
// Cuts scatter-gather segments into pieces so that no part exceeds the
// configured maximum length.
// ----------------------------------------------------------------------------
// Flow: an accepted segment is captured into the segment registers; the
// sequencer then steps the datapath, one piece per cycle while the output
// register is not stalled, from the single take/room datapath loop. A new
// segment is accepted only after the last piece of the previous one is stepped.
// Reset: synchronous, active high; max part length returns to 131072 and a
// fresh request begins (offset zero, full room).
module io_request_part_splitter_unit (
   input  logic                         clock,
   input  logic                         reset,
   // segment transactions
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [iorps_pkg::ADDR_W-1:0] req_seg_addr,
   input  logic [iorps_pkg::SEG_W-1:0]  req_seg_len,
   input  logic                         req_last_segment,
   // piece transactions
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [iorps_pkg::ADDR_W-1:0] rsp_piece_addr,
   output logic [iorps_pkg::SEG_W-1:0]  rsp_piece_len,
   output logic [iorps_pkg::OFFS_W-1:0] rsp_part_offset,
   output logic                         rsp_closes_part,
   output logic [iorps_pkg::PLEN_W-1:0] rsp_part_len,
   output logic                         rsp_last_of_run,
   // max part length register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [iorps_pkg::PLEN_W-1:0] csr_max_part_len
);

   iorps_pkg::cmd_type    cmd;
   iorps_pkg::status_type status;

   // Sequencer: hold the input stalled while a segment is being cut, advance
   // one piece whenever the output register can take it, and drop back to
   // idle once the piece that uses up the segment has been emitted.
   iorps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: segment registers, room left in the current part, part
   // offset, and the output register that parts the two sides so that a
   // new segment may be accepted while a piece still waits to be taken.
   iorps_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_max_part_len (csr_max_part_len),
      .req_seg_addr     (req_seg_addr),
      .req_seg_len      (req_seg_len),
      .req_last_segment (req_last_segment),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_piece_addr   (rsp_piece_addr),
      .rsp_piece_len    (rsp_piece_len),
      .rsp_part_offset  (rsp_part_offset),
      .rsp_closes_part  (rsp_closes_part),
      .rsp_part_len     (rsp_part_len),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

@@ rtl/iorps_ctrl.sv @@
// ----------------------------------------------------------------------------
// iorps_ctrl
// Sequencer: grants configuration writes and accepts one segment while idle,
// then steps the datapath once per piece until the segment is used up.
// ----------------------------------------------------------------------------
module iorps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  iorps_pkg::status_type status,
   output iorps_pkg::cmd_type    cmd
);

   iorps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iorps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.cfg_wr = 1'b0;
      csr_ready  = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         iorps_pkg::ST_IDLE: begin
            csr_ready  = 1'b1;
            // configuration takes priority over a segment in the same cycle
            req_stall  = csr_valid;
            cmd.cfg_wr = csr_valid;
            cmd.load   = req_valid & ~csr_valid;
            if (cmd.load) begin
               state_in = iorps_pkg::ST_RUN;
            end
         end
         iorps_pkg::ST_RUN: begin
            cmd.step = status.out_free;
            if (status.out_free && status.seg_done) begin
               state_in = iorps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iorps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/iorps_datapath.sv @@
// ----------------------------------------------------------------------------
// iorps_datapath
// Segment, part and configuration registers, the per-piece arithmetic and
// the registered result transaction.
// ----------------------------------------------------------------------------
module iorps_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iorps_pkg::cmd_type                   cmd,
   output iorps_pkg::status_type                status,
   input  logic [iorps_pkg::PLEN_W-1:0]         csr_max_part_len,
   input  logic [iorps_pkg::ADDR_W-1:0]         req_seg_addr,
   input  logic [iorps_pkg::SEG_W-1:0]          req_seg_len,
   input  logic                                 req_last_segment,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [iorps_pkg::ADDR_W-1:0]         rsp_piece_addr,
   output logic [iorps_pkg::SEG_W-1:0]          rsp_piece_len,
   output logic [iorps_pkg::OFFS_W-1:0]         rsp_part_offset,
   output logic                                 rsp_closes_part,
   output logic [iorps_pkg::PLEN_W-1:0]         rsp_part_len,
   output logic                                 rsp_last_of_run
);

   logic [iorps_pkg::PLEN_W-1:0] eff_max_ff;
   logic [iorps_pkg::PLEN_W-1:0] room_ff;
   logic [iorps_pkg::OFFS_W-1:0] offset_ff;
   logic [iorps_pkg::ADDR_W-1:0] addr_ff;
   logic [iorps_pkg::SEG_W-1:0]  rem_ff;
   logic                         last_ff;

   logic                         rsp_valid_ff;
   logic [iorps_pkg::ADDR_W-1:0] piece_addr_ff;
   logic [iorps_pkg::SEG_W-1:0]  piece_len_ff;
   logic [iorps_pkg::OFFS_W-1:0] part_offset_ff;
   logic                         closes_part_ff;
   logic [iorps_pkg::PLEN_W-1:0] part_len_ff;
   logic                         last_of_run_ff;

   logic [iorps_pkg::PLEN_W-1:0] cfg_clamped;
   logic [iorps_pkg::SEG_W-1:0]  seg_clamped;
   logic [iorps_pkg::PLEN_W-1:0] rem_ext;
   logic [iorps_pkg::PLEN_W-1:0] take_ext;
   logic [iorps_pkg::SEG_W-1:0]  take;
   logic [iorps_pkg::PLEN_W-1:0] room_in;
   logic [iorps_pkg::SEG_W-1:0]  rem_in;
   logic [iorps_pkg::PLEN_W-1:0] plen;
   logic                         close;
   logic                         rem_zero;

   always_comb begin
      if (csr_max_part_len < iorps_pkg::MAXLEN_LOW) begin
         cfg_clamped = iorps_pkg::MAXLEN_LOW;
      end else if (csr_max_part_len > iorps_pkg::MAXLEN_HIGH) begin
         cfg_clamped = iorps_pkg::MAXLEN_HIGH;
      end else begin
         cfg_clamped = csr_max_part_len;
      end
      seg_clamped = (req_seg_len > iorps_pkg::SEG_LEN_HIGH) ? iorps_pkg::SEG_LEN_HIGH
                                                            : req_seg_len;
   end

   // one piece: take what fits in the room left in the current part
   always_comb begin
      rem_ext  = {{(iorps_pkg::PLEN_W-iorps_pkg::SEG_W){1'b0}}, rem_ff};
      take_ext = (rem_ext < room_ff) ? rem_ext : room_ff;
      take     = take_ext[iorps_pkg::SEG_W-1:0];
      room_in  = room_ff - take_ext;
      rem_in   = rem_ff - take;
      rem_zero = (rem_in == '0);
      close    = (room_in == '0) | (rem_zero & last_ff);
      plen     = eff_max_ff - room_in;
   end

   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign status.seg_done = rem_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_max_ff   <= iorps_pkg::MAXLEN_RESET;
         room_ff      <= iorps_pkg::MAXLEN_RESET;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_wr) begin
            eff_max_ff <= cfg_clamped;
            room_ff    <= cfg_clamped;
            offset_ff  <= '0;
         end else if (cmd.step) begin
            if (rem_zero && last_ff) begin
               offset_ff <= '0;
               room_ff   <= eff_max_ff;
            end else if (close) begin
               offset_ff <= offset_ff + {{(iorps_pkg::OFFS_W-iorps_pkg::PLEN_W){1'b0}}, plen};
               room_ff   <= eff_max_ff;
            end else begin
               room_ff   <= room_in;
            end
         end
         if (cmd.step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_seg_addr;
         rem_ff  <= seg_clamped;
         last_ff <= req_last_segment;
      end else if (cmd.step) begin
         addr_ff <= addr_ff + {{(iorps_pkg::ADDR_W-iorps_pkg::SEG_W){1'b0}}, take};
         rem_ff  <= rem_in;
      end
      if (cmd.step) begin
         piece_addr_ff  <= addr_ff;
         piece_len_ff   <= take;
         part_offset_ff <= offset_ff;
         closes_part_ff <= close;
         part_len_ff    <= close ? plen : '0;
         last_of_run_ff <= rem_zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_piece_addr  = piece_addr_ff;
   assign rsp_piece_len   = piece_len_ff;
   assign rsp_part_offset = part_offset_ff;
   assign rsp_closes_part = closes_part_ff;
   assign rsp_part_len    = part_len_ff;
   assign rsp_last_of_run = last_of_run_ff;

endmodule

@@ rtl/iorps_checker.sv @@
// ----------------------------------------------------------------------------
// iorps_checker
// Port-level checks on the splitter's piece transactions.
// ----------------------------------------------------------------------------
module iorps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [iorps_pkg::ADDR_W-1:0] rsp_piece_addr,
   input logic [iorps_pkg::SEG_W-1:0]  rsp_piece_len,
   input logic                         rsp_closes_part,
   input logic [iorps_pkg::PLEN_W-1:0] rsp_part_len,
   input logic                         rsp_last_of_run
);

   // a stalled piece holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_piece_addr)
                                 && $stable(rsp_piece_len))
      else $error("stalled piece changed");

   // an open part reports no part length
   a_open_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_closes_part |-> rsp_part_len == '0)
      else $error("part length on a piece that does not close");

   // a closing piece lies inside its part; an empty part only ends an empty run
   a_close_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_part |->
         ({5'b0, rsp_piece_len} <= rsp_part_len) &&
         (rsp_part_len != '0 || (rsp_last_of_run && rsp_piece_len == '0)))
      else $error("inconsistent part length on closing piece");

   // an accepted segment keeps the input stalled in the cycle after it is accepted
   a_one_seg: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("segment accepted while previous one is being cut");

endmodule

bind io_request_part_splitter_unit iorps_checker u_iorps_checker (.*);

@@ tb/sv/iorps_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iorps_tb_pkg
// Piece predictor and in-order scoreboard for the request part splitter.
// ----------------------------------------------------------------------------
package iorps_tb_pkg;

   import iorps_pkg::*;

   localparam int unsigned MAX_PIECES = 64;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [SEG_W-1:0]  len;
      logic [OFFS_W-1:0] offset;
      logic              closes;
      logic [PLEN_W-1:0] plen;
      logic              run_end;
   } piece_type;

   class part_split_scoreboard;

      logic [PLEN_W-1:0] max_len_reg = MAXLEN_RESET;
      int unsigned       room_left = MAXLEN_RESET;
      logic [OFFS_W-1:0] part_offset = '0;
      piece_type         expected_pieces[$];
      int unsigned       mismatches = 0;
      int unsigned       pieces_checked = 0;
      int unsigned       segments_noted = 0;
      int unsigned       parts_closed = 0;

      // clamp the register to the legal part length range
      function int unsigned eff_max();
         int unsigned m;
         m = max_len_reg;
         if (m < MAXLEN_LOW) m = MAXLEN_LOW;
         if (m > MAXLEN_HIGH) m = MAXLEN_HIGH;
         return m;
      endfunction

      function void set_max_len(logic [PLEN_W-1:0] value);
         max_len_reg = value;
         room_left   = eff_max();
         part_offset = '0;
      endfunction

      function int unsigned free_room();
         if (room_left == 0 || room_left > eff_max()) return eff_max();
         return room_left;
      endfunction

      function void note_segment(logic [ADDR_W-1:0] addr, logic [SEG_W-1:0] len,
                                 logic last);
         int unsigned m, rem, room, take, n;
         piece_type p;
         m    = eff_max();
         rem  = (len > SEG_LEN_HIGH) ? SEG_LEN_HIGH : len;
         room = free_room();
         n    = 0;
         segments_noted++;
         do begin
            take     = (rem < room) ? rem : room;
            p.addr   = addr;
            p.len    = SEG_W'(take);
            p.offset = part_offset;
            room    -= take;
            rem     -= take;
            p.closes = (room == 0) || (rem == 0 && last);
            p.plen   = '0;
            if (p.closes) begin
               p.plen       = PLEN_W'(m - room);
               part_offset += OFFS_W'(m - room);
               room         = m;
            end
            p.run_end = (rem == 0);
            addr     += ADDR_W'(take);
            expected_pieces.insert(expected_pieces.size(), p);
            n++;
         end while (rem != 0 && n < MAX_PIECES);
         if (last) begin
            part_offset = '0;
            room        = m;
         end
         room_left = room;
      endfunction

      function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
         if (want === got) return 1'b0;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         return 1'b1;
      endfunction

      function void check_piece(piece_type got);
         piece_type want;
         bit bad;
         if (expected_pieces.size() == 0) begin
            $display("%0t ns: piece with nothing expected, addr 0x%0h len %0d",
                     $time, got.addr, got.len);
            mismatches++;
            return;
         end
         want = expected_pieces.pop_front();
         pieces_checked++;
         if (want.closes) parts_closed++;
         bad = 1'b0;
         bad |= field_differs("piece_addr", want.addr, got.addr);
         bad |= field_differs("piece_len", want.len, got.len);
         bad |= field_differs("part_offset", want.offset, got.offset);
         bad |= field_differs("closes_part", want.closes, got.closes);
         bad |= field_differs("part_len", want.plen, got.plen);
         bad |= field_differs("last_of_run", want.run_end, got.run_end);
         if (bad) mismatches++;
      endfunction

   endclass

endpackage

@@ tb/sv/tb_io_request_part_splitter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_io_request_part_splitter_unit
// Feeds scatter-gather segments through the splitter under random sender
// bursts and receiver stalls, predicts every piece and checks it in order,
// across a range of maximum part lengths including clamped settings.
// ----------------------------------------------------------------------------
module tb_io_request_part_splitter_unit;

   import iorps_pkg::*;
   import iorps_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 2_000_000;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned ITEMS_PER_PHASE = 34;
   localparam int unsigned RESET_CYCLES    = 12;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_HALF
   } stall_mode_type;

   logic              clock;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_seg_addr = '0;
   logic [SEG_W-1:0]  req_seg_len = '0;
   logic              req_last_segment = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_piece_addr;
   logic [SEG_W-1:0]  rsp_piece_len;
   logic [OFFS_W-1:0] rsp_part_offset;
   logic              rsp_closes_part;
   logic [PLEN_W-1:0] rsp_part_len;
   logic              rsp_last_of_run;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [PLEN_W-1:0] csr_max_part_len = '0;

   part_split_scoreboard sb;

   int unsigned    burst_left = 0;
   int unsigned    items_sent = 0;
   int unsigned    csr_writes = 0;
   int unsigned    cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   io_request_part_splitter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_seg_addr     (req_seg_addr),
      .req_seg_len      (req_seg_len),
      .req_last_segment (req_last_segment),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_piece_addr   (rsp_piece_addr),
      .rsp_piece_len    (rsp_piece_len),
      .rsp_part_offset  (rsp_part_offset),
      .rsp_closes_part  (rsp_closes_part),
      .rsp_part_len     (rsp_part_len),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_part_len (csr_max_part_len)
   );

   // Receiver back-pressure: switch between stall patterns every so often,
   // including long stretches with no stall at all.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Sample each piece transaction on the edge that accepts it; values read
   // here are the ones held before the edge.
   always @(posedge clock) begin : piece_monitor
      piece_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.addr    = rsp_piece_addr;
         got.len     = rsp_piece_len;
         got.offset  = rsp_part_offset;
         got.closes  = rsp_closes_part;
         got.plen    = rsp_part_len;
         got.run_end = rsp_last_of_run;
         sb.check_piece(got);
      end
   end

   // Watchdog: abandon the run if it overruns the cycle budget.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run exceeded %0d cycles, %0d pieces still expected",
               CYCLE_LIMIT, sb.expected_pieces.size());
      $display("Test completed with failures");
      $finish;
   end

   // Present one segment and hold it until accepted. The sender works in
   // bursts; between bursts it may drop valid for a random gap. Called just after
   // a rising edge, so each step sees at most one update of req_valid.
   task automatic send_segment(input logic [ADDR_W-1:0] addr,
                               input logic [SEG_W-1:0] len, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_seg_addr     <= addr;
      req_seg_len      <= len;
      req_last_segment <= last;
      do @(posedge clock); while (req_stall);
      sb.note_segment(addr, len, last);
      items_sent++;
   endtask

   // Drop valid, wait for every expected piece, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_pieces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the maximum part length while the block is idle; this also starts
   // a fresh request.
   task automatic write_max_len(input logic [PLEN_W-1:0] value);
      drain();
      csr_valid        <= 1'b1;
      csr_max_part_len <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_max_len(value);
      csr_writes++;
   endtask

   // Mostly full-range addresses; some just below the top so pieces wrap.
   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 99) < 15)
         return {32'hFFFF_FFFF, 16'hFFFF, 16'($urandom_range(0, 65535))};
      return {$urandom, $urandom};
   endfunction

   // Segment length mix: zero, exact fill of the open part, full 16-bit range,
   // oversized, and a bulk up to twice a part below 16384, else up to 20000.
   function automatic logic [SEG_W-1:0] pick_len();
      int unsigned m, lim, r;
      m = sb.eff_max();
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 25 && sb.free_room() <= SEG_LEN_HIGH) return SEG_W'(sb.free_room());
      if (r < 35) return SEG_W'($urandom_range(0, 65535));
      if (r < 40) return SEG_W'($urandom_range(SEG_LEN_HIGH, 65535));
      lim = (m < 16384) ? 2 * m : 20000;
      return SEG_W'($urandom_range(1, lim));
   endfunction

   // One request of a few segments; now and then leave it open so that the
   // next one runs on into the same part.
   task automatic send_random_request();
      int unsigned nseg;
      logic last;
      nseg = $urandom_range(1, 6);
      for (int unsigned i = 0; i < nseg; i++) begin
         last = (i == nseg - 1) && ($urandom_range(0, 7) != 0);
         send_segment(pick_addr(), pick_len(), last);
      end
   endtask

   initial begin
      logic [PLEN_W-1:0] settings[10];
      int unsigned phase_start;
      sb = new;
      settings = '{MAXLEN_LOW, MAXLEN_HIGH, '1, PLEN_W'(5000), PLEN_W'(1023),
                   PLEN_W'(1048577), PLEN_W'($urandom_range(1024, 1048576)),
                   PLEN_W'(1100), MAXLEN_RESET, '0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset length of 131072 first.
      send_segment('0, '0, 1'b1);                        // empty request
      send_segment('1, '0, 1'b0);                        // zero length mid request
      send_segment(64'h1000, SEG_LEN_HIGH, 1'b0);
      send_segment(64'h0000_8000_0000_0000, '1, 1'b0);   // oversized, saturates
      send_segment(64'hFFFF_FFFF_FFFF_FF00, 16'd3000, 1'b0); // split, address wraps
      send_segment(64'h2000, SEG_LEN_HIGH, 1'b0);
      send_segment(64'h3000, SEG_LEN_HIGH, 1'b0);
      send_segment(64'h4000, 16'd1096, 1'b0);            // fills the part exactly
      send_segment(64'h5000, '0, 1'b1);                  // empty tail after exact fill
      send_segment(pick_addr(), 16'd5000, 1'b1);

      // Smallest part: a segment that yields the most pieces.
      write_max_len(MAXLEN_LOW);
      send_segment(64'h100, 16'd100, 1'b0);
      send_segment(64'h1_0000, SEG_LEN_HIGH, 1'b1);
      send_segment(64'hABC, 16'd1024, 1'b1);
      send_segment(64'hDEF0, 16'd1024, 1'b0);
      send_segment(64'hDEF0, '0, 1'b1);

      // Out-of-range register values clamp at both ends.
      write_max_len('0);
      send_segment(64'h7, 16'd2500, 1'b1);
      write_max_len('1);
      send_segment(pick_addr(), '1, 1'b1);

      // Random part, one phase per setting.
      foreach (settings[i]) begin
         write_max_len(settings[i]);
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) send_random_request();
      end

      drain();
      repeat (16) @(posedge clock);

      if (sb.expected_pieces.size() != 0) begin
         $display("%0t ns: %0d expected pieces never arrived",
                  $time, sb.expected_pieces.size());
         sb.mismatches++;
      end

      $display("Sent %0d segments, checked %0d pieces closing %0d parts",
               sb.segments_noted, sb.pieces_checked, sb.parts_closed);
      $display("Used %0d length settings, clamped ones included; %0d bad pieces",
               csr_writes, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
